/* sv/steam_cycle_sequencer_defines.svh */
// assertion macros for the steam cycle sequencer
// used by the top level; expects clk and arst_n in scope
`ifndef STEAM_CYCLE_SEQUENCER_DEFINES_SVH
`define STEAM_CYCLE_SEQUENCER_DEFINES_SVH

// same-cycle implication
`define SCS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SCS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* sv/scs_pkg.sv */
// shared types and constants of the steam cycle sequencer
// no dependencies; imported by scs_tick and the top level
`default_nettype none

package scs_pkg;

	typedef enum logic [7:0] {
		PH_IDLE    = 8'b0000_0001,
		PH_PREHEAT = 8'b0000_0010,
		PH_HIGH    = 8'b0000_0100,
		PH_MID     = 8'b0000_1000,
		PH_LOW     = 8'b0001_0000,
		PH_COOL    = 8'b0010_0000,
		PH_DONE    = 8'b0100_0000,
		PH_ERROR   = 8'b1000_0000
	} phase_t;

	// phase codes as seen on the result port
	localparam logic [2:0] CODE_IDLE    = 3'd0;
	localparam logic [2:0] CODE_PREHEAT = 3'd1;
	localparam logic [2:0] CODE_HIGH    = 3'd2;
	localparam logic [2:0] CODE_MID     = 3'd3;
	localparam logic [2:0] CODE_LOW     = 3'd4;
	localparam logic [2:0] CODE_COOL    = 3'd5;
	localparam logic [2:0] CODE_DONE    = 3'd6;
	localparam logic [2:0] CODE_ERROR   = 3'd7;

	localparam logic [1:0] CAUSE_NONE   = 2'd0;
	localparam logic [1:0] CAUSE_SILENT = 2'd1;
	localparam logic [1:0] CAUSE_RANGE  = 2'd2;
	localparam logic [1:0] CAUSE_OVER   = 2'd3;

	localparam logic [1:0] SEL_PREHEAT = 2'd0;
	localparam logic [1:0] SEL_HIGH    = 2'd1;
	localparam logic [1:0] SEL_MID     = 2'd2;
	localparam logic [1:0] SEL_LOW     = 2'd3;

	localparam logic [2:0] REG_MAX_TEMP   = 3'd0;
	localparam logic [2:0] REG_PREHEAT    = 3'd1;
	localparam logic [2:0] REG_SAFE_OPEN  = 3'd2;
	localparam logic [2:0] REG_HIGH_TICKS = 3'd3;
	localparam logic [2:0] REG_MID_TICKS  = 3'd4;
	localparam logic [2:0] REG_LOW_TICKS  = 3'd5;
	localparam logic [2:0] REG_DUTY_CAP   = 3'd6;
	localparam logic [2:0] REG_MIN_ON     = 3'd7;

	localparam int CFG_W = 11;

	localparam logic [10:0] MAX_TEMP_RST   = 11'd1520;
	localparam logic [10:0] PREHEAT_RST    = 11'd1040;
	localparam logic [10:0] SAFE_OPEN_RST  = 11'd640;
	localparam logic [7:0]  HIGH_TICKS_RST = 8'd90;
	localparam logic [7:0]  MID_TICKS_RST  = 8'd90;
	localparam logic [7:0]  LOW_TICKS_RST  = 8'd60;
	localparam logic [9:0]  DUTY_CAP_RST   = 10'd900;
	localparam logic [10:0] MIN_ON_RST     = 11'd50;

	localparam logic signed [12:0] TEMP_LO        = -13'sd160;
	localparam logic signed [12:0] TEMP_HI        = 13'sd2000;
	localparam logic signed [12:0] RESET_MARGIN   = 13'sd160;
	localparam logic signed [12:0] PREHEAT_MARGIN = 13'sd32;
	localparam logic [9:0]  DUTY_FULL = 10'd1000;
	localparam logic [10:0] ON_MS_SAT = 11'h7FF;
	localparam logic [7:0]  TICK_SAT  = 8'hFF;
	localparam logic [1:0]  FAIL_SAT  = 2'd3;

	typedef struct packed {
		logic [10:0] max_temp;
		logic [10:0] preheat_temp;
		logic [10:0] safe_open_temp;
		logic [7:0]  high_phase_ticks;
		logic [7:0]  mid_phase_ticks;
		logic [7:0]  low_phase_ticks;
		logic [9:0]  duty_cap;
		logic [10:0] min_on_ms;
	} cfg_t;

	typedef struct packed {
		phase_t             ph;
		logic [7:0]         ticks;
		logic [1:0]         fails;
		logic signed [11:0] last_temp;
		logic               fan;
		logic [1:0]         tsel;
	} state_t;

	typedef struct packed {
		logic [2:0]  phase;
		logic [10:0] heater_on_ms;
		logic        fan_on;
		logic [1:0]  setpoint_select;
		logic        pid_clear;
		logic        pid_used;
		logic [9:0]  duty_applied;
		logic [1:0]  error_cause;
	} result_t;

	function automatic logic [2:0] phase_code(phase_t p);
		logic [2:0] c;
		case (p)
			PH_IDLE:    c = CODE_IDLE;
			PH_PREHEAT: c = CODE_PREHEAT;
			PH_HIGH:    c = CODE_HIGH;
			PH_MID:     c = CODE_MID;
			PH_LOW:     c = CODE_LOW;
			PH_COOL:    c = CODE_COOL;
			PH_DONE:    c = CODE_DONE;
			PH_ERROR:   c = CODE_ERROR;
			default:    c = CODE_IDLE;
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

/* sv/scs_tick.sv */
// next-state and result logic for one control tick
// depends on scs_pkg
`default_nettype none

module scs_tick #(
	parameter int PERIOD_MS  = 2000,
	parameter int FAIL_LIMIT = 3
) (
	input  scs_pkg::cfg_t      cfg,
	input  scs_pkg::state_t    cur,
	input  logic signed [11:0] temperature,
	input  logic               read_ok,
	input  logic               button_pressed,
	input  logic [9:0]         pid_duty,
	output scs_pkg::state_t    nxt,
	output scs_pkg::result_t   res
);
	import scs_pkg::*;

	// on-time = duty * PERIOD_MS / 1000 via a rounded-up reciprocal
	localparam int ON_SHIFT = 24;
	localparam longint unsigned ON_MULT =
		(longint'(PERIOD_MS) * (64'd1 << ON_SHIFT) + 64'd999) / 64'd1000;
	localparam int MULT_W = $clog2(ON_MULT + 1);
	localparam int PROD_W = 10 + MULT_W;
	localparam int ON_W   = PROD_W - ON_SHIFT;
	localparam int CMP_W  = (ON_W > 11) ? ON_W : 11;

	logic [9:0]        duty_lim;
	logic [9:0]        duty;
	logic [PROD_W-1:0] prod;
	logic [CMP_W-1:0]  on_ext;
	logic [10:0]       on_ms;

	assign duty_lim = (cfg.duty_cap > DUTY_FULL) ? DUTY_FULL : cfg.duty_cap;
	assign duty     = (pid_duty > duty_lim) ? duty_lim : pid_duty;
	assign prod     = PROD_W'(duty) * PROD_W'(ON_MULT);
	assign on_ext   = CMP_W'(prod[PROD_W-1:ON_SHIFT]);

	always_comb begin
		if (on_ext < CMP_W'(cfg.min_on_ms)) begin
			on_ms = '0;
		end else if (on_ext > CMP_W'(ON_MS_SAT)) begin
			on_ms = ON_MS_SAT;
		end else begin
			on_ms = on_ext[10:0];
		end
	end

	always_comb begin
		logic               skip;
		logic [1:0]         cause;
		logic               clr;
		logic               used;
		logic signed [12:0] t13;
		logic signed [12:0] lt13;
		logic signed [12:0] max13;
		logic [7:0]         lim_t;

		nxt   = cur;
		skip  = 1'b0;
		cause = CAUSE_NONE;
		clr   = 1'b0;
		used  = 1'b0;
		lim_t = cfg.low_phase_ticks;
		t13   = {temperature[11], temperature};
		max13 = $signed({2'b00, cfg.max_temp});

		if (read_ok) begin
			nxt.last_temp = temperature;
		end
		lt13 = {nxt.last_temp[11], nxt.last_temp};

		// safety checks, skipped once tripped
		if (nxt.ph != PH_ERROR) begin
			if (!read_ok) begin
				if (nxt.fails != FAIL_SAT) begin
					nxt.fails = nxt.fails + 2'd1;
				end
				if (nxt.fails >= 2'(FAIL_LIMIT)) begin
					cause = CAUSE_SILENT;
				end
				skip = 1'b1;
			end else begin
				nxt.fails = '0;
				if (t13 < TEMP_LO || t13 > TEMP_HI) begin
					cause = CAUSE_RANGE;
				end else if (t13 >= max13) begin
					cause = CAUSE_OVER;
				end
				if (cause != CAUSE_NONE) begin
					skip = 1'b1;
				end
			end
			if (cause != CAUSE_NONE) begin
				clr       = 1'b1;
				nxt.ph    = PH_ERROR;
				nxt.ticks = '0;
			end
		end

		if (!skip) begin
			if (button_pressed) begin
				if (nxt.ph inside {PH_IDLE, PH_DONE}) begin
					clr       = 1'b1;
					nxt.tsel  = SEL_PREHEAT;
					nxt.ph    = PH_PREHEAT;
					nxt.ticks = '0;
				end else if (nxt.ph == PH_ERROR) begin
					if (lt13 < max13 - RESET_MARGIN) begin
						nxt.fan   = 1'b0;
						clr       = 1'b1;
						nxt.ph    = PH_IDLE;
						nxt.ticks = '0;
					end
				end else begin
					// manual stop
					clr       = 1'b1;
					nxt.ticks = '0;
					if (lt13 > $signed({2'b00, cfg.safe_open_temp})) begin
						nxt.fan = 1'b1;
						nxt.ph  = PH_COOL;
					end else begin
						nxt.fan = 1'b0;
						nxt.ph  = PH_DONE;
					end
				end
			end

			case (nxt.ph)
				PH_PREHEAT, PH_HIGH, PH_MID, PH_LOW: begin
					used = 1'b1;
					if (nxt.ph == PH_PREHEAT) begin
						if (lt13 >= $signed({2'b00, cfg.preheat_temp}) - PREHEAT_MARGIN) begin
							nxt.tsel  = SEL_HIGH;
							nxt.ph    = PH_HIGH;
							nxt.ticks = '0;
						end
					end else begin
						if (nxt.ph == PH_HIGH) begin
							lim_t = cfg.high_phase_ticks;
						end else if (nxt.ph == PH_MID) begin
							lim_t = cfg.mid_phase_ticks;
						end
						if (nxt.ticks != TICK_SAT) begin
							nxt.ticks = nxt.ticks + 8'd1;
						end
						if (nxt.ticks >= lim_t) begin
							if (nxt.ph == PH_HIGH) begin
								nxt.tsel = SEL_MID;
								nxt.ph   = PH_MID;
							end else if (nxt.ph == PH_MID) begin
								nxt.tsel = SEL_LOW;
								nxt.ph   = PH_LOW;
							end else begin
								clr     = 1'b1;
								nxt.fan = 1'b1;
								nxt.ph  = PH_COOL;
							end
							nxt.ticks = '0;
						end
					end
				end
				PH_COOL: begin
					nxt.fan = 1'b1;
					if (lt13 < $signed({2'b00, cfg.safe_open_temp})) begin
						nxt.fan   = 1'b0;
						nxt.ph    = PH_DONE;
						nxt.ticks = '0;
					end
				end
				PH_ERROR: begin
					nxt.fan = 1'b1;
				end
				default: begin
					nxt.fan = 1'b0;
				end
			endcase
		end

		res.phase           = phase_code(nxt.ph);
		res.heater_on_ms    = used ? on_ms : '0;
		res.fan_on          = nxt.fan;
		res.setpoint_select = nxt.tsel;
		res.pid_clear       = clr;
		res.pid_used        = used;
		res.duty_applied    = used ? duty : '0;
		res.error_cause     = cause;
	end

endmodule

`default_nettype wire

/* sv/steam_cycle_sequencer.sv */
// steam cycle sequencer: an input beat passes through the input register,
// then the result register, to its result beat; one beat per cycle sustained
// while out_stall is low, set by the state update loop through scs_tick
// arst_n clears phase to idle, counters, last temperature, fan and selection,
// and loads the register defaults; both pipeline slots come up empty
`default_nettype none

module steam_cycle_sequencer #(
	parameter int PERIOD_MS  = 2000,
	parameter int FAIL_LIMIT = 3
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [2:0]            cfg_index,
	input  logic [scs_pkg::CFG_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic signed [11:0]    temperature,
	input  logic                  read_ok,
	input  logic                  button_pressed,
	input  logic [9:0]            pid_duty,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [2:0]            phase,
	output logic [10:0]           heater_on_ms,
	output logic                  fan_on,
	output logic [1:0]            setpoint_select,
	output logic                  pid_clear,
	output logic                  pid_used,
	output logic [9:0]            duty_applied,
	output logic [1:0]            error_cause
);
	import scs_pkg::*;

	`include "steam_cycle_sequencer_defines.svh"

	cfg_t               cfg_q;
	state_t             state_q;
	state_t             state_nxt;
	result_t            res_nxt;
	result_t            res_q;
	logic               res_valid_q;
	logic               valid_s1;
	logic signed [11:0] temp_s1;
	logic               ok_s1;
	logic               btn_s1;
	logic [9:0]         duty_s1;
	logic               adv;

	// result slot frees when empty or its beat is taken
	assign adv      = !res_valid_q || !out_stall;
	assign in_stall = valid_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_temp         <= MAX_TEMP_RST;
			cfg_q.preheat_temp     <= PREHEAT_RST;
			cfg_q.safe_open_temp   <= SAFE_OPEN_RST;
			cfg_q.high_phase_ticks <= HIGH_TICKS_RST;
			cfg_q.mid_phase_ticks  <= MID_TICKS_RST;
			cfg_q.low_phase_ticks  <= LOW_TICKS_RST;
			cfg_q.duty_cap         <= DUTY_CAP_RST;
			cfg_q.min_on_ms        <= MIN_ON_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MAX_TEMP:   cfg_q.max_temp         <= cfg_data[10:0];
				REG_PREHEAT:    cfg_q.preheat_temp     <= cfg_data[10:0];
				REG_SAFE_OPEN:  cfg_q.safe_open_temp   <= cfg_data[10:0];
				REG_HIGH_TICKS: cfg_q.high_phase_ticks <= cfg_data[7:0];
				REG_MID_TICKS:  cfg_q.mid_phase_ticks  <= cfg_data[7:0];
				REG_LOW_TICKS:  cfg_q.low_phase_ticks  <= cfg_data[7:0];
				REG_DUTY_CAP:   cfg_q.duty_cap         <= cfg_data[9:0];
				REG_MIN_ON:     cfg_q.min_on_ms        <= cfg_data[10:0];
				default:        cfg_q.max_temp         <= cfg_q.max_temp;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			temp_s1 <= temperature;
			ok_s1   <= read_ok;
			btn_s1  <= button_pressed;
			duty_s1 <= pid_duty;
		end
	end

	scs_tick #(
		.PERIOD_MS  (PERIOD_MS),
		.FAIL_LIMIT (FAIL_LIMIT)
	) u_tick (
		.cfg            (cfg_q),
		.cur            (state_q),
		.temperature    (temp_s1),
		.read_ok        (ok_s1),
		.button_pressed (btn_s1),
		.pid_duty       (duty_s1),
		.nxt            (state_nxt),
		.res            (res_nxt)
	);

	// state moves on only when the beat in the input register is retired
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.ph        <= PH_IDLE;
			state_q.ticks     <= '0;
			state_q.fails     <= '0;
			state_q.last_temp <= '0;
			state_q.fan       <= 1'b0;
			state_q.tsel      <= SEL_PREHEAT;
			res_valid_q       <= 1'b0;
		end else if (adv) begin
			res_valid_q <= valid_s1;
			if (valid_s1) begin
				state_q <= state_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s1) begin
			res_q <= res_nxt;
		end
	end

	assign out_valid       = res_valid_q;
	assign phase           = res_q.phase;
	assign heater_on_ms    = res_q.heater_on_ms;
	assign fan_on          = res_q.fan_on;
	assign setpoint_select = res_q.setpoint_select;
	assign pid_clear       = res_q.pid_clear;
	assign pid_used        = res_q.pid_used;
	assign duty_applied    = res_q.duty_applied;
	assign error_cause     = res_q.error_cause;

	`SCS_ASSERT_NOW(a_stall_needs_item, in_stall, valid_s1 && res_valid_q && out_stall, "input stalled without a blocked beat")
	`SCS_ASSERT_NOW(a_cause_means_error, out_valid && error_cause != CAUSE_NONE, phase == CODE_ERROR && pid_clear, "trip beat not in error phase")
	`SCS_ASSERT_NOW(a_heat_only_when_used, out_valid && heater_on_ms != 11'd0, pid_used && duty_applied != 10'd0, "heater on outside a heating phase")
	`SCS_ASSERT_NEXT(a_state_held_when_blocked, !adv, $stable(state_q), "state changed while result slot blocked")

endmodule

`default_nettype wire
